FILE: src/plti_pkg.sv
package plti_pkg;

   localparam int MAX_POINTS    = 64;
   localparam int ELEMENT_COUNT = 8;

   // Field widths of the request and response beats.
   localparam int ELEM_W  = 3;
   localparam int ROW_W   = $clog2(MAX_POINTS);
   localparam int WORD_W  = 24;
   localparam int PTS_W   = $clog2(MAX_POINTS + 1);

   // Magnitude of offset times value difference, and the divider length.
   localparam int PROD_W    = 2 * (WORD_W + 1);
   localparam int MAG_W     = 2 * WORD_W;
   localparam int DIV_STEPS = MAG_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic REQ_QUERY = 1'b0;
   localparam logic REQ_LOAD  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PRE0,
      ST_PRE1,
      ST_SRCH,
      ST_VAL0,
      ST_VAL1,
      ST_VAL2,
      ST_MUL,
      ST_DINIT,
      ST_DIV,
      ST_FIN,
      ST_MISS
   } ctrl_state_type;

   typedef struct packed {
      logic             load_wr;
      logic             latch_query;
      logic             bp_rd;
      logic [ROW_W-1:0] bp_addr;
      logic             lo_load;
      logic             hit_load;
      logic             val_rd;
      logic [ROW_W-1:0] val_row;
      logic             v0_load;
      logic             dv_load;
      logic             mul;
      logic             div_init;
      logic             div_step;
      logic             out_load;
      logic             out_found;
   } dp_cmd_type;

   typedef struct packed {
      logic elem_ok;
      logic hit;
      logic rsp_busy;
   } dp_status_type;

endpackage

FILE: src/plti_ctrl.sv
module plti_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic                       req_type,
   input  logic [plti_pkg::PTS_W-1:0] points,
   input  plti_pkg::dp_status_type    status,
   output plti_pkg::dp_cmd_type       cmd
);
   import plti_pkg::*;

   ctrl_state_type   state_ff, state_in;
   logic [ROW_W-1:0] k_ff, k_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [PTS_W-1:0] n_ff, n_in;
   logic [PTS_W-1:0] n_clamped;
   logic             accept;
   logic             last_interval;

   assign n_clamped     = (points > PTS_W'(MAX_POINTS)) ? PTS_W'(MAX_POINTS) : points;
   assign accept        = req_tvalid && req_tready;
   assign last_interval = ({1'b0, k_ff} + PTS_W'(2)) >= n_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff     <= '0;
         cnt_ff   <= '0;
         n_ff     <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         cnt_ff   <= cnt_in;
         n_ff     <= n_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      cnt_in   = cnt_ff;
      n_in     = n_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_type == REQ_QUERY) begin
               n_in = n_clamped;
               k_in = '0;
               if (!status.elem_ok || n_clamped < PTS_W'(2)) begin
                  state_in = ST_MISS;
               end else begin
                  state_in = ST_PRE0;
               end
            end
         end
         ST_PRE0: state_in = ST_PRE1;
         ST_PRE1: state_in = ST_SRCH;
         ST_SRCH: begin
            if (status.hit) begin
               state_in = ST_VAL0;
            end else if (last_interval) begin
               state_in = ST_MISS;
            end else begin
               k_in = k_ff + ROW_W'(1);
            end
         end
         ST_VAL0:  state_in = ST_VAL1;
         ST_VAL1:  state_in = ST_VAL2;
         ST_VAL2:  state_in = ST_MUL;
         ST_MUL:   state_in = ST_DINIT;
         ST_DINIT: begin
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN, ST_MISS: begin
            if (!status.rsp_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd         = '0;
      req_tready  = (state_ff == ST_IDLE);
      cmd.load_wr = accept && req_type == REQ_LOAD;
      unique case (state_ff)
         ST_IDLE: cmd.latch_query = accept && req_type == REQ_QUERY;
         ST_PRE0: begin
            cmd.bp_rd   = 1'b1;
            cmd.bp_addr = '0;
         end
         ST_PRE1: begin
            cmd.bp_rd   = 1'b1;
            cmd.bp_addr = ROW_W'(1);
            cmd.lo_load = 1'b1;
         end
         ST_SRCH: begin
            cmd.hit_load = 1'b1;
            if (!status.hit && !last_interval) begin
               cmd.bp_rd   = 1'b1;
               cmd.bp_addr = k_ff + ROW_W'(2);
               cmd.lo_load = 1'b1;
            end
         end
         ST_VAL0: begin
            cmd.val_rd  = 1'b1;
            cmd.val_row = k_ff;
         end
         ST_VAL1: begin
            cmd.val_rd  = 1'b1;
            cmd.val_row = k_ff + ROW_W'(1);
            cmd.v0_load = 1'b1;
         end
         ST_VAL2:  cmd.dv_load  = 1'b1;
         ST_MUL:   cmd.mul      = 1'b1;
         ST_DINIT: cmd.div_init = 1'b1;
         ST_DIV:   cmd.div_step = 1'b1;
         ST_FIN: begin
            cmd.out_load  = !status.rsp_busy;
            cmd.out_found = 1'b1;
         end
         ST_MISS: cmd.out_load = !status.rsp_busy;
         default: cmd = '0;
      endcase
   end

endmodule

FILE: src/plti_dp.sv
module plti_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  plti_pkg::dp_cmd_type               cmd,
   input  logic [plti_pkg::ELEM_W-1:0]        element_sel,
   input  logic [plti_pkg::ROW_W-1:0]         point_index,
   input  logic [plti_pkg::WORD_W-1:0]        position,
   input  logic signed [plti_pkg::WORD_W-1:0] factor_value,
   output plti_pkg::dp_status_type            status,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic signed [plti_pkg::WORD_W-1:0] interp_value,
   output logic                               in_range
);
   import plti_pkg::*;

   localparam int VAL_DEPTH = ELEMENT_COUNT * MAX_POINTS;

   logic [WORD_W-1:0]        bp_mem [MAX_POINTS];
   logic signed [WORD_W-1:0] val_mem [VAL_DEPTH];

   logic [WORD_W-1:0]        bp_rd_ff;
   logic signed [WORD_W-1:0] val_rd_ff;
   logic [WORD_W-1:0]        pos_ff;
   logic [ELEM_W-1:0]        elem_ff;
   logic [WORD_W-1:0]        lo_ff;
   logic [WORD_W-1:0]        off_ff;
   logic [WORD_W-1:0]        span_ff;
   logic signed [WORD_W-1:0] v0_ff;
   logic signed [WORD_W:0]   dv_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic                     neg_ff;
   logic [MAG_W-1:0]         num_ff;
   logic [WORD_W-1:0]        rem_ff;
   logic                     rsp_valid_ff;
   logic signed [WORD_W-1:0] rsp_value_ff;
   logic                     rsp_found_ff;

   logic [PROD_W-1:0]        prod_abs;
   logic [WORD_W:0]          trial;
   logic                     trial_fits;
   logic [WORD_W:0]          quot;
   logic [WORD_W:0]          sum;

   assign status.elem_ok  = {1'b0, element_sel} < (ELEM_W + 1)'(ELEMENT_COUNT);
   assign status.hit      = (pos_ff >= lo_ff) && (pos_ff < bp_rd_ff);
   assign status.rsp_busy = rsp_valid_ff && !rsp_tready;

   // Table stores.
   always_ff @(posedge clock) begin
      if (cmd.load_wr && status.elem_ok) begin
         bp_mem[point_index] <= position;
      end
      if (cmd.bp_rd) begin
         bp_rd_ff <= bp_mem[cmd.bp_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_wr && status.elem_ok) begin
         val_mem[{element_sel, point_index}] <= factor_value;
      end
      if (cmd.val_rd) begin
         val_rd_ff <= val_mem[{elem_ff, cmd.val_row}];
      end
   end

   assign prod_abs   = prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
   assign trial      = {rem_ff, num_ff[MAG_W-1]};
   assign trial_fits = trial >= {1'b0, span_ff};
   assign quot       = num_ff[WORD_W:0];
   assign sum        = neg_ff ? ((WORD_W + 1)'(signed'(v0_ff)) - quot)
                              : ((WORD_W + 1)'(signed'(v0_ff)) + quot);

   // Search, multiply and restoring divide.
   always_ff @(posedge clock) begin
      if (cmd.latch_query) begin
         pos_ff  <= position;
         elem_ff <= element_sel;
      end
      if (cmd.lo_load) begin
         lo_ff <= bp_rd_ff;
      end
      if (cmd.hit_load) begin
         off_ff  <= pos_ff - lo_ff;
         span_ff <= bp_rd_ff - lo_ff;
      end
      if (cmd.v0_load) begin
         v0_ff <= val_rd_ff;
      end
      if (cmd.dv_load) begin
         dv_ff <= (WORD_W + 1)'(val_rd_ff) - (WORD_W + 1)'(v0_ff);
      end
      if (cmd.mul) begin
         prod_ff <= $signed({1'b0, off_ff}) * dv_ff;
      end
      if (cmd.div_init) begin
         neg_ff <= prod_ff[PROD_W-1];
         num_ff <= prod_abs[MAG_W-1:0];
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         if (trial_fits) begin
            rem_ff <= WORD_W'(trial - {1'b0, span_ff});
         end else begin
            rem_ff <= trial[WORD_W-1:0];
         end
         num_ff <= {num_ff[MAG_W-2:0], trial_fits};
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_found_ff <= cmd.out_found;
         rsp_value_ff <= cmd.out_found ? signed'(sum[WORD_W-1:0]) : '0;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign interp_value = rsp_value_ff;
   assign in_range     = rsp_found_ff;

endmodule

FILE: src/piecewise_linear_table_interpolator.sv
// Channel   Direction  Handshake              Payload
// req_      in         req_tvalid/req_tready  tdata: element_sel, point_index, position,
//                                             factor_value; tuser: req_type
// rsp_      out        rsp_tvalid/rsp_tready  tdata: interp_value; tuser: in_range
// csr_      in         APB, pready tied high  register 0 at byte address 0: points_in_use
//
// A load beat with a valid element writes its row straight into both table memories.
// A query first searches the breakpoint memory, read one row a cycle, for the matching
// interval, then reads the two values, multiplies, runs the bit-serial divider and loads
// the response register. A query that misses answers after the search alone; one with an
// invalid element or fewer than two points in use answers without a search.
// Reset is synchronous; it clears the controller, the response valid and points_in_use
// (to 64). The tables are not cleared. A waiting response does not block loads; a
// finished query holds in the controller until the response register is free.
module piecewise_linear_table_interpolator (
   input  logic                                  clock,
   input  logic                                  reset,
   // From the lowest bit up: element_sel[2:0], point_index[8:3], position[32:9],
   // factor_value[56:33], zero fill.
   input  logic [63:0]                           req_tdata,
   // req_type.
   input  logic                                  req_tuser,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // interp_value[23:0].
   output logic [23:0]                           rsp_tdata,
   // in_range.
   output logic                                  rsp_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [plti_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [plti_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [plti_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);
   import plti_pkg::*;

   logic [PTS_W-1:0]         points_ff;
   logic                     reg_sel;
   dp_cmd_type               cmd;
   dp_status_type            status;
   logic signed [WORD_W-1:0] interp_value;
   logic                     in_range;

   // Register 0 lives in the lower word; bit 2 of the byte address picks the word.
   assign reg_sel    = !csr_paddr[2];
   assign csr_pready = 1'b1;
   assign csr_prdata = reg_sel ? CSR_DATA_W'(points_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         points_ff <= PTS_W'(MAX_POINTS);
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && reg_sel) begin
         points_ff <= csr_pwdata[PTS_W-1:0];
      end
   end

   plti_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_type   (req_tuser),
      .points     (points_ff),
      .status     (status),
      .cmd        (cmd)
   );

   plti_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .element_sel  (req_tdata[2:0]),
      .point_index  (req_tdata[8:3]),
      .position     (req_tdata[32:9]),
      .factor_value (signed'(req_tdata[56:33])),
      .status       (status),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .interp_value (interp_value),
      .in_range     (in_range)
   );

   assign rsp_tdata = interp_value;
   assign rsp_tuser = in_range;

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import plti_pkg::*;

   // Cycles to let pass after the last response before touching the register,
   // and at the end of the run.
   localparam int SETTLE_CYCLES = 130;
   // Cycles with no beat on any channel before the run is declared hung. The
   // longest legal quiet spell is the receiver hold-off plus one slow query.
   localparam int QUIET_LIMIT   = 5000;
   localparam int HOLD_OFF      = 600;
   localparam int PHASE_ITEMS   = 28;
   // Breakpoint spacing used when the tables are first filled.
   localparam int FILL_STEP     = 'h40000;

   localparam logic [CSR_ADDR_W-1:0] ADDR_POINTS = 3'd0;
   // Byte address of register index one, which does not exist.
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNUSED = 3'd4;

   typedef struct packed {
      logic        kind;
      logic [2:0]  elem;
      logic [5:0]  row;
      logic [23:0] pos;
      logic [23:0] fval;
      logic        wait_idle;
   } table_req_type;

   typedef struct packed {
      logic [23:0] value;
      logic        in_range;
   } answer_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   // From the lowest bit up: element_sel[2:0], point_index[8:3], position[32:9],
   // factor_value[56:33], zero fill.
   logic [63:0]           req_tdata   = '0;
   // req_type.
   logic                  req_tuser   = 1'b0;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   // interp_value[23:0].
   logic [23:0]           rsp_tdata;
   // in_range.
   logic                  rsp_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Requests waiting to be offered, and the beat currently on the bus.
   table_req_type req_backlog[$];
   table_req_type on_bus;
   // Answers predicted for accepted queries, oldest first.
   answer_type    pending_answers[$];

   // The predictor's copy of the block state, updated as beats are accepted.
   logic [23:0]        shadow_bp [MAX_POINTS];
   logic signed [23:0] shadow_val [ELEMENT_COUNT][MAX_POINTS];
   logic [6:0]         shadow_points = 7'd64;

   // The generator's view of the tables, updated as beats are queued. It runs
   // ahead of the predictor and is only used to pick interesting positions.
   logic [23:0]        plan_bp [MAX_POINTS];
   logic [6:0]         plan_points = 7'd64;

   int queued_count  = 0;
   int beats_taken   = 0;
   int loads_taken   = 0;
   int queries_taken = 0;
   int answers_seen  = 0;
   int hits_seen     = 0;
   int settings_used = 0;
   int mismatches    = 0;
   int quiet_cycles  = 0;
   int stall_left    = 0;
   bit held_off      = 1'b0;

   piecewise_linear_table_interpolator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      $display("ERROR at %0t: %s: got %h, expected %h", $time, what, got, want);
      mismatches++;
   endtask

   // Interval search and interpolation over the shadow tables. The first
   // interval with bp[i] <= pos < bp[i+1] wins; an interval whose span is not
   // positive can never match. The quotient is truncated toward zero, which is
   // what signed division does here.
   function automatic answer_type interpolate(input logic [2:0] elem,
                                              input logic [23:0] pos);
      answer_type ans;
      int         n;
      longint     off, span, v0, v1, q;
      ans.value    = '0;
      ans.in_range = 1'b0;
      n = (shadow_points > MAX_POINTS) ? MAX_POINTS : shadow_points;
      if (elem < ELEMENT_COUNT && n >= 2) begin
         for (int i = 0; i + 1 < n; i++) begin
            if (!ans.in_range && pos >= shadow_bp[i] && pos < shadow_bp[i+1]) begin
               off  = {40'd0, pos} - {40'd0, shadow_bp[i]};
               span = {40'd0, shadow_bp[i+1]} - {40'd0, shadow_bp[i]};
               v0   = shadow_val[elem][i];
               v1   = shadow_val[elem][i+1];
               q    = (off * (v1 - v0)) / span;
               ans.value    = 24'(v0 + q);
               ans.in_range = 1'b1;
            end
         end
      end
      return ans;
   endfunction

   // A load writes one breakpoint and one value at the same row; a query
   // leaves an answer behind.
   function automatic void apply_request(input table_req_type b);
      if (b.kind == REQ_LOAD) begin
         loads_taken++;
         if (b.elem < ELEMENT_COUNT && b.row < MAX_POINTS) begin
            shadow_bp[b.row]          = b.pos;
            shadow_val[b.elem][b.row] = b.fval;
         end
      end else begin
         queries_taken++;
         pending_answers.push_back(interpolate(b.elem, b.pos));
      end
   endfunction

   // Mostly random table values, with the two extremes now and then.
   function automatic logic [23:0] rand_value();
      int roll;
      roll = $urandom_range(9);
      if (roll == 0)
         return 24'h800000;
      else if (roll == 1)
         return 24'h7FFFFF;
      return 24'($urandom);
   endfunction

   task automatic push_load(input logic [2:0] elem, input logic [5:0] row,
                            input logic [23:0] pos, input logic [23:0] fval);
      table_req_type b;
      b = '{kind: REQ_LOAD, elem: elem, row: row, pos: pos, fval: fval, wait_idle: 1'b0};
      plan_bp[row] = pos;
      req_backlog.push_back(b);
      queued_count++;
   endtask

   // The row and value fields of a query carry noise; the block ignores them.
   task automatic push_query(input logic [2:0] elem, input logic [23:0] pos,
                             input logic wait_idle);
      table_req_type b;
      b = '{kind: REQ_QUERY, elem: elem, row: 6'($urandom), pos: pos,
            fval: 24'($urandom), wait_idle: wait_idle};
      req_backlog.push_back(b);
      queued_count++;
   endtask

   // Rewrite every breakpoint in ascending order, along with one element's
   // values. Style 0 is the even fill spacing, 1 is tightly packed rows, 2 is
   // random gaps and 3 allows repeated breakpoints (zero-width intervals).
   task automatic rebuild_table(input logic [2:0] elem, input int style);
      logic [23:0] bp;
      unique case (style)
         0: bp = '0;
         1: bp = 24'($urandom_range(24'hFFFFFF - 1024));
         default: bp = 24'($urandom_range(FILL_STEP - 1));
      endcase
      for (int r = 0; r < MAX_POINTS; r++) begin
         if (r > 0) begin
            unique case (style)
               0: bp += 24'(FILL_STEP);
               1: bp += 24'($urandom_range(16, 1));
               2: bp += 24'($urandom_range(FILL_STEP - 1, 1));
               default: bp += 24'($urandom_range(FILL_STEP - 1, 0));
            endcase
         end
         push_load(elem, 6'(r), bp, rand_value());
      end
   endtask

   // Wait until every queued beat has been taken and answered, then give the
   // block time to finish any work that produces no response.
   task automatic finish_phase();
      while (beats_taken != queued_count || pending_answers.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic check_points_readback();
      logic [31:0] rd;
      csr_access(1'b0, ADDR_POINTS, 32'd0, rd);
      if (rd[6:0] !== shadow_points)
         flag_mismatch("points_in_use readback", {25'd0, rd[6:0]}, {25'd0, shadow_points});
   endtask

   // Only the low seven bits hold the register; the rest of the write data is
   // noise that must be dropped.
   task automatic set_points(input logic [6:0] value);
      logic [31:0] rd;
      csr_access(1'b1, ADDR_POINTS, {25'($urandom), value}, rd);
      shadow_points = value;
      plan_points   = value;
      settings_used++;
      check_points_readback();
   endtask

   // Driver. A beat stays on the bus until it is taken; a new one is offered
   // only when the bus is free, at random about 62 times in a hundred, except
   // during a stretch of beats with no gaps. A beat marked wait_idle is held
   // back until every answer so far has arrived.
   always @(posedge clock) begin
      table_req_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            apply_request(on_bus);
            beats_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_backlog.size() != 0
                && !(req_backlog[0].wait_idle && pending_answers.size() != 0)
                && ((beats_taken >= 700 && beats_taken < 900)
                    || $urandom_range(99) >= 38)) begin
               nxt = req_backlog.pop_front();
               on_bus     <= nxt;
               req_tdata  <= {7'd0, nxt.fval, nxt.pos, nxt.row, nxt.elem};
               req_tuser  <= nxt.kind;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor. Each response beat is checked against the oldest answer. Once,
   // while the sender still has plenty queued, the receiver holds off for a
   // long stretch so that the response register and the controller fill up
   // and the input stalls.
   always @(posedge clock) begin
      answer_type want;
      logic       ready_next;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            answers_seen++;
            if (rsp_tuser)
               hits_seen++;
            if (pending_answers.size() == 0) begin
               flag_mismatch("response with no query outstanding",
                             {7'd0, rsp_tuser, rsp_tdata}, 32'd0);
            end else begin
               want = pending_answers.pop_front();
               if (rsp_tdata !== want.value)
                  flag_mismatch("interp_value", {8'd0, rsp_tdata}, {8'd0, want.value});
               if (rsp_tuser !== want.in_range)
                  flag_mismatch("in_range", {31'd0, rsp_tuser}, {31'd0, want.in_range});
            end
         end
         if (!held_off && answers_seen >= 20 && req_backlog.size() >= 20) begin
            held_off   = 1'b1;
            stall_left = HOLD_OFF;
         end
         if (stall_left > 0) begin
            stall_left--;
            ready_next = 1'b0;
         end else begin
            ready_next = (answers_seen >= 100 && answers_seen < 150)
                         || ($urandom_range(99) >= 38);
         end
         rsp_tready <= ready_next;
      end
   end

   // Any beat on any channel counts as progress.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_psel && csr_penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT)
         @(posedge clock);
      $display("no progress for %0d cycles", QUIET_LIMIT);
      $display("piecewise_linear_table_interpolator: mismatch");
      $finish;
   end

   initial begin
      logic [6:0]  point_settings [9];
      logic [31:0] rd;
      logic [23:0] lo, hi, pos;
      logic [2:0]  elem;
      int          roll, n, row, i;

      point_settings = '{7'd2, 7'd127, 7'd0, 7'd1, 7'd65, 7'd3, 7'd17, 7'd64, 7'd40};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // The register must come out of reset at 64.
      check_points_readback();

      // Write every row of every element first, so that no query can ever
      // touch a table entry that has not been written. The last pass leaves
      // the breakpoints evenly spaced.
      for (int e = 0; e < ELEMENT_COUNT; e++)
         rebuild_table(3'(e), 0);

      // Directed part. The first interval spans the full value range.
      push_load(3'd0, 6'd0, 24'h000000, 24'h800000);
      push_load(3'd0, 6'd1, 24'(FILL_STEP), 24'h7FFFFF);
      push_query(3'd0, 24'h000000, 1'b0);                // on a breakpoint
      push_query(3'd0, 24'(FILL_STEP - 1), 1'b0);        // just below the next one
      push_query(3'd0, 24'h020001, 1'b0);
      // The top row at the largest position: the longest search, and a
      // position equal to the last breakpoint, which lies outside.
      push_load(3'd7, 6'd63, 24'hFFFFFF, 24'h7FFFFF);
      push_load(3'd7, 6'd62, 24'(62 * FILL_STEP), 24'h800000);
      push_query(3'd7, 24'hFFFFFE, 1'b0);
      push_query(3'd7, 24'hFFFFFF, 1'b0);
      // A zero-width interval is skipped in favor of the next one.
      push_load(3'd3, 6'd11, 24'(10 * FILL_STEP), rand_value());
      push_query(3'd3, 24'(10 * FILL_STEP), 1'b0);
      // An out-of-order breakpoint widens interval 19, which then shadows the
      // intervals after it.
      push_load(3'd5, 6'd20, 24'hF00000, rand_value());
      push_query(3'd5, 24'(19 * FILL_STEP + 5), 1'b0);
      push_query(3'd5, 24'(21 * FILL_STEP + 7), 1'b0);
      // A position below the first breakpoint.
      push_load(3'd2, 6'd0, 24'h000100, rand_value());
      push_query(3'd2, 24'h000050, 1'b0);
      push_query(3'd4, 24'h7FFFFF, 1'b0);
      push_query(3'd6, 24'h000000, 1'b0);                // below the table again

      // Random part, one register setting per phase. The first four phases
      // start with a fresh ascending table, one for each spacing style; every
      // phase mixes loads that keep the order, a few noise loads, and queries
      // aimed mostly inside the table.
      for (int p = 0; p < 9; p++) begin
         finish_phase();
         set_points(point_settings[p]);
         if (p == 2) begin
            // A write to a register that does not exist changes nothing.
            csr_access(1'b1, ADDR_UNUSED, $urandom, rd);
            check_points_readback();
         end
         if (p < 4)
            rebuild_table(3'($urandom), p);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            roll = (p == 4 && k == PHASE_ITEMS / 2) ? 99 : $urandom_range(99);
            elem = 3'($urandom);
            n    = (plan_points > MAX_POINTS) ? MAX_POINTS : plan_points;
            if (roll < 15) begin
               row = $urandom_range(MAX_POINTS - 1);
               lo  = (row > 0) ? plan_bp[row-1] : 24'h000000;
               hi  = (row < MAX_POINTS - 1) ? plan_bp[row+1] : 24'hFFFFFF;
               pos = (hi >= lo) ? 24'($urandom_range(hi, lo)) : 24'($urandom);
               push_load(elem, 6'(row), pos, rand_value());
            end else if (roll < 19) begin
               push_load(elem, 6'($urandom), 24'($urandom), rand_value());
            end else if (roll < 27) begin
               push_query(elem, 24'($urandom), 1'b0);
            end else if (roll < 35) begin
               push_query(elem, plan_bp[$urandom_range(MAX_POINTS - 1)], 1'b0);
            end else begin
               pos = 24'($urandom);
               if (n >= 2) begin
                  i  = $urandom_range(n - 2);
                  lo = plan_bp[i];
                  hi = plan_bp[i+1];
                  if (hi > lo)
                     pos = 24'($urandom_range(hi - 1, lo));
               end
               // Once, the sender stops until every answer is back.
               push_query(elem, pos, p == 4 && k == PHASE_ITEMS / 2);
            end
         end
      end

      finish_phase();
      $display("covered %0d beats: %0d loads and %0d queries, %0d answers (%0d in range)",
               beats_taken, loads_taken, queries_taken, answers_seen, hits_seen);
      $display("over %0d point-count settings, with one long receiver hold-off",
               settings_used);
      if (mismatches == 0)
         $display("piecewise_linear_table_interpolator: match");
      else
         $display("piecewise_linear_table_interpolator: mismatch");
      $finish;
   end

endmodule
